// ===== hdl/rsa_pkg.sv =====
package rsa_pkg;
	localparam int PRIME_BITS_DEF = 32;
	localparam int WIDE = 64;

	// datapath commands
	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_LOAD  = 3'd1;
	localparam logic [2:0] CMD_GCD   = 3'd2;
	localparam logic [2:0] CMD_NEXT  = 3'd3;
	localparam logic [2:0] CMD_INV   = 3'd4;

	typedef struct packed {
		logic [2:0] cmd;
	} rsa_cmd_t;

	typedef struct packed {
		logic done;
		logic err;
		logic coprime;
	} rsa_stat_t;
endpackage

// ===== hdl/rsa_exponent_pair_generator.sv =====
// rsa exponent pair generator
// pulse start while busy is low with prime_p and prime_q on the ports; the
// transaction is taken at that edge and busy rises the next cycle.
// the block forms modulus = p*q and totient n = (p-1)(q-1), searches the
// smallest public exponent from 2 coprime to n by euclid gcd, then the
// private exponent by extended euclid; both searches share one radix-2
// restoring divider.
// each euclid step is one division; a gcd takes up to about 90 steps, and
// for the inverse a shift-and-add modular multiply of the quotient follows
// each division before the coefficients are updated.
// one item at a time; valid is high for exactly one cycle with the result on
// the result ports, and busy drops then. no_exponent is set when a
// factor is below two or the totient is two or less, exponents then 0.
// the receiver cannot stall. reset (arst_n low) returns to idle at once.
module rsa_exponent_pair_generator #(
	parameter int PRIME_BITS = rsa_pkg::PRIME_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [31:0]              prime_p,
	input  logic [31:0]              prime_q,
	output logic                     valid,
	output logic [rsa_pkg::WIDE-1:0] modulus,
	output logic [rsa_pkg::WIDE-1:0] public_exponent,
	output logic [rsa_pkg::WIDE-1:0] private_exponent,
	output logic                     no_exponent
);
	import rsa_pkg::*;

	rsa_cmd_t  cmd;
	rsa_stat_t stat;

	rsa_controller u_ctl (
		.clk(clk), .arst_n(arst_n), .start(start), .stat(stat),
		.cmd(cmd), .busy(busy), .valid(valid)
	);

	rsa_datapath #(.PRIME_BITS(PRIME_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.prime_p(prime_p), .prime_q(prime_q), .stat(stat),
		.modulus(modulus), .public_exponent(public_exponent),
		.private_exponent(private_exponent)
	);

	assign no_exponent = stat.err;

	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(busy)) else $error("result without transaction");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("start not taken");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && no_exponent) |-> (public_exponent == '0 && private_exponent == '0))
		else $error("error result carries exponent");
endmodule

// ===== hdl/rsa_divider.sv =====
module rsa_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [rsa_pkg::WIDE-1:0]   dividend,
	input  logic [rsa_pkg::WIDE-1:0]   divisor,
	output logic                       done,
	output logic [rsa_pkg::WIDE-1:0]   quotient,
	output logic [rsa_pkg::WIDE-1:0]   remainder
);
	import rsa_pkg::*;

	logic [WIDE-1:0] quo_q;
	logic [WIDE:0]   rem_q;
	logic [WIDE-1:0] dvs_q;
	logic [6:0]      cnt_q;
	logic            run_q;
	logic [WIDE:0]   shifted;
	logic [WIDE:0]   diff;

	// restoring division, one quotient bit a cycle
	assign shifted = {rem_q[WIDE-1:0], quo_q[WIDE-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= 7'(WIDE);
			end else if (run_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			if (!diff[WIDE]) begin
				rem_q <= diff;
				quo_q <= {quo_q[WIDE-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[WIDE-2:0], 1'b0};
			end
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q[WIDE-1:0];
endmodule

// ===== hdl/rsa_datapath.sv =====
module rsa_datapath #(
	parameter int PRIME_BITS = rsa_pkg::PRIME_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rsa_pkg::rsa_cmd_t         cmd,
	input  logic [31:0]               prime_p,
	input  logic [31:0]               prime_q,
	output rsa_pkg::rsa_stat_t        stat,
	output logic [rsa_pkg::WIDE-1:0]  modulus,
	output logic [rsa_pkg::WIDE-1:0]  public_exponent,
	output logic [rsa_pkg::WIDE-1:0]  private_exponent
);
	import rsa_pkg::*;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_MUL  = 3'd1;
	localparam logic [2:0] PH_DIV  = 3'd2;
	localparam logic [2:0] PH_WAIT = 3'd3;
	localparam logic [2:0] PH_MM   = 3'd4;
	localparam logic [2:0] PH_UPD  = 3'd5;

	logic [2:0]      ph_q;
	logic            inv_q;
	logic [1:0]      mcnt_q;
	logic [PRIME_BITS-1:0] p_q, q_q;
	logic [WIDE-1:0] n_q, i_q, a_q, b_q, c0_q, c1_q;
	logic [WIDE-1:0] acc_q, ma_q, mb_q, nc;
	logic            dgo, ddone;
	logic [WIDE-1:0] dquo, drem;
	logic [WIDE-1:0] sum_acc, dbl;

	function automatic logic [WIDE-1:0] addm(input logic [WIDE-1:0] x,
		input logic [WIDE-1:0] y, input logic [WIDE-1:0] n);
		logic [WIDE-1:0] t;
		t = n - y;
		return (x >= t) ? x - t : x + y;
	endfunction

	rsa_divider u_div (
		.clk(clk), .arst_n(arst_n), .go(dgo),
		.dividend(a_q), .divisor(b_q),
		.done(ddone), .quotient(dquo), .remainder(drem)
	);

	assign dgo     = (ph_q == PH_DIV);
	assign sum_acc = addm(acc_q, ma_q, n_q);
	assign dbl     = addm(ma_q, ma_q, n_q);
	assign nc      = (c0_q >= acc_q) ? c0_q - acc_q : c0_q + (n_q - acc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
			stat <= '0;
			inv_q <= 1'b0;
			mcnt_q <= '0;
		end else begin
			stat.done <= 1'b0;
			case (ph_q)
				PH_IDLE: begin
					case (cmd.cmd)
						CMD_LOAD: begin
							ph_q <= PH_MUL;
							mcnt_q <= '0;
						end
						CMD_GCD: begin
							// candidate is never zero, so a division always follows
							inv_q <= 1'b0;
							ph_q <= PH_DIV;
						end
						CMD_INV: begin
							inv_q <= 1'b1;
							ph_q <= PH_DIV;
						end
						default: ;
					endcase
					if (cmd.cmd == CMD_NEXT)
						stat.done <= 1'b1;
				end
				PH_MUL: begin
					// two registered multiplies: modulus then totient
					mcnt_q <= mcnt_q + 2'd1;
					if (mcnt_q == 2'd2) begin
						ph_q <= PH_IDLE;
						stat.done <= 1'b1;
						stat.err <= (p_q < 2) || (q_q < 2) || (n_q <= 64'd2);
					end
				end
				PH_DIV: ph_q <= PH_WAIT;
				PH_WAIT: begin
					if (ddone)
						ph_q <= inv_q ? PH_MM : PH_UPD;
				end
				PH_MM: begin
					if (mb_q == '0)
						ph_q <= PH_UPD;
				end
				PH_UPD: begin
					if (drem == '0) begin
						ph_q <= PH_IDLE;
						stat.done <= 1'b1;
						stat.coprime <= (b_q == 64'd1);
					end else begin
						ph_q <= PH_DIV;
					end
				end
				default: ph_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ph_q)
			PH_IDLE: begin
				case (cmd.cmd)
					CMD_LOAD: begin
						p_q <= prime_p[PRIME_BITS-1:0];
						q_q <= prime_q[PRIME_BITS-1:0];
						i_q <= 64'd2;
					end
					CMD_GCD: begin
						a_q <= n_q;
						b_q <= i_q;
					end
					CMD_NEXT: i_q <= i_q + 64'd1;
					CMD_INV: begin
						a_q <= n_q;
						b_q <= i_q;
						c0_q <= '0;
						c1_q <= 64'd1;
					end
					default: ;
				endcase
			end
			PH_MUL: begin
				if (mcnt_q == 2'd0)
					modulus <= WIDE'(p_q) * WIDE'(q_q);
				else
					n_q <= WIDE'(p_q - PRIME_BITS'(1)) * WIDE'(q_q - PRIME_BITS'(1));
			end
			PH_WAIT: begin
				if (ddone) begin
					acc_q <= '0;
					ma_q <= (dquo >= n_q) ? dquo - n_q : dquo;
					mb_q <= c1_q;
				end
			end
			PH_MM: begin
				if (mb_q != '0) begin
					if (mb_q[0])
						acc_q <= sum_acc;
					ma_q <= dbl;
					mb_q <= mb_q >> 1;
				end
			end
			PH_UPD: begin
				a_q <= b_q;
				b_q <= drem;
				if (inv_q) begin
					c0_q <= c1_q;
					c1_q <= nc;
				end
			end
			default: ;
		endcase
	end

	// quotient below 2n always, so one subtract reduces it
	assign public_exponent  = stat.err ? '0 : i_q;
	assign private_exponent = stat.err ? '0 : c0_q;
endmodule

// ===== hdl/rsa_controller.sv =====
module rsa_controller (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  rsa_pkg::rsa_stat_t stat,
	output rsa_pkg::rsa_cmd_t  cmd,
	output logic               busy,
	output logic               valid
);
	import rsa_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_GCD  = 3'd2;
	localparam logic [2:0] ST_NEXT = 3'd3;
	localparam logic [2:0] ST_INV  = 3'd4;
	localparam logic [2:0] ST_WAIT = 3'd5;

	logic [2:0] st_q;
	logic [2:0] after_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			after_q <= ST_IDLE;
			valid <= 1'b0;
		end else begin
			valid <= 1'b0;
			case (st_q)
				ST_IDLE: if (start) begin
					st_q <= ST_WAIT;
					after_q <= ST_LOAD;
				end
				ST_GCD: begin
					st_q <= ST_WAIT;
					after_q <= ST_GCD;
				end
				ST_NEXT: begin
					st_q <= ST_WAIT;
					after_q <= ST_NEXT;
				end
				ST_INV: begin
					st_q <= ST_WAIT;
					after_q <= ST_INV;
				end
				ST_WAIT: begin
					if (stat.done) begin
						case (after_q)
							ST_LOAD: begin
								if (stat.err) begin
									st_q <= ST_IDLE;
									valid <= 1'b1;
								end else st_q <= ST_GCD;
							end
							ST_GCD: st_q <= stat.coprime ? ST_INV : ST_NEXT;
							ST_NEXT: st_q <= ST_GCD;
							default: begin
								st_q <= ST_IDLE;
								valid <= 1'b1;
							end
						endcase
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// load goes out with the accepted transaction so the primes are taken at that edge
	always_comb begin
		case (st_q)
			ST_IDLE: cmd.cmd = start ? CMD_LOAD : CMD_NONE;
			ST_GCD:  cmd.cmd = CMD_GCD;
			ST_NEXT: cmd.cmd = CMD_NEXT;
			ST_INV:  cmd.cmd = CMD_INV;
			default: cmd.cmd = CMD_NONE;
		endcase
	end

	assign busy = (st_q != ST_IDLE);
endmodule
